@@ src/dthc_pkg.sv @@
// ----------------------------------------------------------------------------
// dthc_pkg
// Shared types and constants for the depth-to-hue colormap pipeline.
// ----------------------------------------------------------------------------
package dthc_pkg;

	localparam int DEPTH_W = 16;
	localparam int PCT_W   = 7;
	localparam int CHAN_W  = 8;
	localparam int Q_W     = 23;    // depth * 72 fits in 23 bits
	localparam int FRAC_W  = 16;
	localparam int UQ_W    = 17;    // Q.16 values up to and including 1.0
	localparam int SEC_W   = 3;

	localparam logic [Q_W-1:0]    HUE_LIMIT = 23'd393216;   // 6.0 in Q.16
	localparam logic [UQ_W-1:0]   FRAC_ONE  = 17'h10000;
	localparam logic [PCT_W-1:0]  PCT_MAX   = 7'd100;
	// ceil(2^32 / 100): percent times this, shifted right by 16, is floor(p*65536/100)
	localparam logic [25:0]       PCT_RECIP = 26'd42949673;

	// Configuration register indexes
	localparam logic [1:0] REG_SATURATION = 2'd0;
	localparam logic [1:0] REG_BRIGHTNESS = 2'd1;

	// Sector codes of the six-sector HSV rule
	localparam logic [SEC_W-1:0] SEC_RED_GREEN  = 3'd0;
	localparam logic [SEC_W-1:0] SEC_GREEN_RED  = 3'd1;
	localparam logic [SEC_W-1:0] SEC_GREEN_BLUE = 3'd2;
	localparam logic [SEC_W-1:0] SEC_BLUE_GREEN = 3'd3;
	localparam logic [SEC_W-1:0] SEC_BLUE_RED   = 3'd4;

	typedef struct packed {
		logic             valid;
		logic             oor;
		logic [SEC_W-1:0] sector;
		logic [UQ_W-1:0]  t;
		logic [UQ_W-1:0]  s_q;
		logic [UQ_W-1:0]  v_q;
	} hue_s1_t;

	typedef struct packed {
		logic             valid;
		logic             oor;
		logic [SEC_W-1:0] sector;
		logic [UQ_W-1:0]  c_q;
		logic [UQ_W-1:0]  x_q;
		logic [UQ_W-1:0]  m_q;
	} chroma_s3_t;

	// Clamp a percent to 100 and convert it to Q.16
	function automatic logic [UQ_W-1:0] pct_to_q16(input logic [PCT_W-1:0] pct);
		logic [PCT_W-1:0] p;
		logic [32:0]      prod;
		p    = (pct > PCT_MAX) ? PCT_MAX : pct;
		prod = 33'(p) * 33'(PCT_RECIP);
		return prod[32:16];
	endfunction

endpackage

@@ src/dthc_hue_stage.sv @@
// ----------------------------------------------------------------------------
// dthc_hue_stage
// Stage 1: hue in sextants, sector, ramp and Q.16 saturation and value.
// ----------------------------------------------------------------------------
module dthc_hue_stage (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic [dthc_pkg::DEPTH_W-1:0]   depth_mm,
	input  logic [dthc_pkg::PCT_W-1:0]     sat_pct,
	input  logic [dthc_pkg::PCT_W-1:0]     bri_pct,
	output dthc_pkg::hue_s1_t              hue_s1
);

	logic [dthc_pkg::Q_W-1:0]    q;
	logic [dthc_pkg::SEC_W-1:0]  sector;
	logic [dthc_pkg::FRAC_W-1:0] frac;
	logic [dthc_pkg::UQ_W-1:0]   t;

	// depth * 72 = depth * 64 + depth * 8
	assign q      = {1'b0, depth_mm, 6'b0} + {4'b0, depth_mm, 3'b0};
	assign sector = q[dthc_pkg::FRAC_W +: dthc_pkg::SEC_W];
	assign frac   = q[dthc_pkg::FRAC_W-1:0];
	assign t      = sector[0] ? (dthc_pkg::FRAC_ONE - {1'b0, frac}) : {1'b0, frac};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_s1 <= '0;
		end else begin
			hue_s1.valid  <= in_valid;
			hue_s1.oor    <= (q > dthc_pkg::HUE_LIMIT);
			hue_s1.sector <= sector;
			hue_s1.t      <= t;
			hue_s1.s_q    <= dthc_pkg::pct_to_q16(sat_pct);
			hue_s1.v_q    <= dthc_pkg::pct_to_q16(bri_pct);
		end
	end

endmodule

@@ src/dthc_chroma_stage.sv @@
// ----------------------------------------------------------------------------
// dthc_chroma_stage
// Stages 2 and 3: chroma C = S*V, then second component X = C*t and m = V-C.
// ----------------------------------------------------------------------------
module dthc_chroma_stage (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dthc_pkg::hue_s1_t     hue_s1,
	output dthc_pkg::chroma_s3_t  chroma_s3
);

	logic                        valid_s2;
	logic                        oor_s2;
	logic [dthc_pkg::SEC_W-1:0]  sector_s2;
	logic [dthc_pkg::UQ_W-1:0]   t_s2;
	logic [dthc_pkg::UQ_W-1:0]   c_s2;
	logic [dthc_pkg::UQ_W-1:0]   v_s2;

	logic [2*dthc_pkg::UQ_W-1:0] sv_prod;
	logic [2*dthc_pkg::UQ_W-1:0] ct_prod;

	assign sv_prod = 34'(hue_s1.s_q) * 34'(hue_s1.v_q);
	assign ct_prod = 34'(c_s2) * 34'(t_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2  <= 1'b0;
			chroma_s3 <= '0;
		end else begin
			valid_s2         <= hue_s1.valid;
			chroma_s3.valid  <= valid_s2;
			chroma_s3.oor    <= oor_s2;
			chroma_s3.sector <= sector_s2;
			chroma_s3.c_q    <= c_s2;
			chroma_s3.x_q    <= ct_prod[dthc_pkg::FRAC_W +: dthc_pkg::UQ_W];
			chroma_s3.m_q    <= v_s2 - c_s2;
		end
	end

	always_ff @(posedge clk) begin
		oor_s2    <= hue_s1.oor;
		sector_s2 <= hue_s1.sector;
		t_s2      <= hue_s1.t;
		v_s2      <= hue_s1.v_q;
		c_s2      <= sv_prod[dthc_pkg::FRAC_W +: dthc_pkg::UQ_W];
	end

	// Chroma never exceeds value, so m stays non-negative
	a_c_le_v: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (c_s2 <= v_s2))
		else $error("chroma above value");

endmodule

@@ src/dthc_rgb_stage.sv @@
// ----------------------------------------------------------------------------
// dthc_rgb_stage
// Stage 4: sector select, add m, scale to 0..255, blank out of range hues.
// ----------------------------------------------------------------------------
module dthc_rgb_stage (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dthc_pkg::chroma_s3_t          chroma_s3,
	output logic                          result_valid,
	output logic [dthc_pkg::CHAN_W-1:0]   red,
	output logic [dthc_pkg::CHAN_W-1:0]   green,
	output logic [dthc_pkg::CHAN_W-1:0]   blue,
	output logic                          out_of_range
);

	logic [dthc_pkg::UQ_W-1:0] r_c, g_c, b_c;

	function automatic logic [dthc_pkg::CHAN_W-1:0] to_chan(
		input logic [dthc_pkg::UQ_W-1:0] comp,
		input logic [dthc_pkg::UQ_W-1:0] m
	);
		logic [dthc_pkg::UQ_W:0] sum;
		logic [25:0]             scaled;
		logic [9:0]              top;
		sum    = {1'b0, comp} + {1'b0, m};
		// sum * 255 = sum * 256 - sum
		scaled = {sum, 8'b0} - 26'(sum);
		top    = scaled[25:16];
		return (top > 10'd255) ? 8'd255 : top[7:0];
	endfunction

	always_comb begin
		case (chroma_s3.sector)
			dthc_pkg::SEC_RED_GREEN: begin
				r_c = chroma_s3.c_q; g_c = chroma_s3.x_q; b_c = '0;
			end
			dthc_pkg::SEC_GREEN_RED: begin
				r_c = chroma_s3.x_q; g_c = chroma_s3.c_q; b_c = '0;
			end
			dthc_pkg::SEC_GREEN_BLUE: begin
				r_c = '0; g_c = chroma_s3.c_q; b_c = chroma_s3.x_q;
			end
			dthc_pkg::SEC_BLUE_GREEN: begin
				r_c = '0; g_c = chroma_s3.x_q; b_c = chroma_s3.c_q;
			end
			dthc_pkg::SEC_BLUE_RED: begin
				r_c = chroma_s3.x_q; g_c = '0; b_c = chroma_s3.c_q;
			end
			default: begin
				// last sector, and exactly 360 degrees
				r_c = chroma_s3.c_q; g_c = '0; b_c = chroma_s3.x_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= chroma_s3.valid;
		end
	end

	always_ff @(posedge clk) begin
		out_of_range <= chroma_s3.oor;
		if (chroma_s3.oor) begin
			red   <= '0;
			green <= '0;
			blue  <= '0;
		end else begin
			red   <= to_chan(r_c, chroma_s3.m_q);
			green <= to_chan(g_c, chroma_s3.m_q);
			blue  <= to_chan(b_c, chroma_s3.m_q);
		end
	end

endmodule

@@ src/depth_to_hue_colormap_core.sv @@
// ----------------------------------------------------------------------------
// depth_to_hue_colormap_core
// Maps a depth pixel in millimetres to an RGB color through an HSV hue ramp.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive depth_mm and pulse start. A request is taken at
//   every rising edge with start high and busy low. busy is held low, so a
//   new pixel can enter on every cycle: one pixel per clock sustained.
//   Result channel: result_valid is high for exactly one cycle with red,
//   green, blue and out_of_range, after the registers of the hue stage,
//   chroma multiply, ramp multiply and channel scaling. The receiver
//   cannot stall; results leave in request order.
//   Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data.
//   Index 0 is saturation in percent, index 1 brightness in percent; other
//   indexes are dropped. cfg_ready is always high. Write only while no
//   request is in flight.
//   Reset: arst_n low clears all valid bits and sets both percents to 100.
//   Hues above 360 degrees (depth_mm above 5461) give out_of_range and a
//   black color.
// ----------------------------------------------------------------------------
module depth_to_hue_colormap_core (
	input  logic                          clk,
	input  logic                          arst_n,
	// pixel requests
	input  logic                          start,
	output logic                          busy,
	input  logic [dthc_pkg::DEPTH_W-1:0]  depth_mm,
	// results
	output logic                          result_valid,
	output logic [dthc_pkg::CHAN_W-1:0]   red,
	output logic [dthc_pkg::CHAN_W-1:0]   green,
	output logic [dthc_pkg::CHAN_W-1:0]   blue,
	output logic                          out_of_range,
	// configuration writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [dthc_pkg::PCT_W-1:0]    cfg_data
);

	logic [dthc_pkg::PCT_W-1:0] sat_pct_q;
	logic [dthc_pkg::PCT_W-1:0] bri_pct_q;
	logic                       accept;

	dthc_pkg::hue_s1_t    hue_s1;
	dthc_pkg::chroma_s3_t chroma_s3;

	// Pipeline never stalls: take a request on every cycle
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// Configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_pct_q <= dthc_pkg::PCT_MAX;
			bri_pct_q <= dthc_pkg::PCT_MAX;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dthc_pkg::REG_SATURATION: sat_pct_q <= cfg_data;
				dthc_pkg::REG_BRIGHTNESS: bri_pct_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1: hue sector, ramp, percent to Q.16
	dthc_hue_stage u_hue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.depth_mm (depth_mm),
		.sat_pct  (sat_pct_q),
		.bri_pct  (bri_pct_q),
		.hue_s1   (hue_s1)
	);

	// Stages 2 and 3: chroma, second component, offset
	dthc_chroma_stage u_chroma (
		.clk       (clk),
		.arst_n    (arst_n),
		.hue_s1    (hue_s1),
		.chroma_s3 (chroma_s3)
	);

	// Stage 4: channel select and scaling to bytes
	dthc_rgb_stage u_rgb (
		.clk          (clk),
		.arst_n       (arst_n),
		.chroma_s3    (chroma_s3),
		.result_valid (result_valid),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.out_of_range (out_of_range)
	);

	// An out-of-range result carries black
	a_oor_black: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && out_of_range) |-> (red == '0 && green == '0 && blue == '0))
		else $error("out-of-range result is not black");

	// Every accepted request reaches stage 1 on the next edge
	a_s1_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> hue_s1.valid)
		else $error("request lost at stage 1");

	// Every valid stage 3 entry is followed by a result strobe
	a_out_follows: assert property (@(posedge clk) disable iff (!arst_n)
		chroma_s3.valid |=> result_valid)
		else $error("stage 3 entry dropped");

	// Ramp component never exceeds chroma for in-range hues
	a_x_le_c: assert property (@(posedge clk) disable iff (!arst_n)
		(chroma_s3.valid && !chroma_s3.oor) |-> (chroma_s3.x_q <= chroma_s3.c_q))
		else $error("second component above chroma");

endmodule
